[sv/atq_pkg.sv]
// Shared types and codes for the alarm timer queue.
`default_nettype none
package atq_pkg;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_TICK     = 2'd1,
    OP_CLEAR    = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_WAKEUP    = 3'd1,
    EV_MESSAGE   = 3'd2,
    EV_SCHEDULED = 3'd3,
    EV_SCHED_SLP = 3'd4,
    EV_FULL      = 3'd5,
    EV_CLEARED   = 3'd6,
    EV_SILENT    = 3'd7
  } event_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_TICK
  } back_state_e;

  localparam int unsigned MaxOut  = 16;
  localparam int unsigned PopCntW = 4;
  localparam int unsigned InTimeW = 48;

  typedef struct packed {
    opcode_e     op;
    logic [15:0] proc;
    logic        sleep;
    logic        msg;
    logic [15:0] queue;
    logic [15:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [15:0] proc;
    logic [31:0] id;
    logic        sleep;
    logic        msg;
    logic [15:0] queue;
    logic [15:0] handle;
  } entry_t;

endpackage
`default_nettype wire

[sv/atq_front.sv]
// Front end: accepts requests, drops undefined opcodes, queues commands.
`default_nettype none
module atq_front
  import atq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [InTimeW-1:0]   time_value_i,
  input  wire logic [15:0]          process_id_i,
  input  wire logic                 sleep_request_i,
  input  wire logic                 has_message_i,
  input  wire logic [15:0]          queue_descriptor_i,
  input  wire logic [15:0]          message_handle_i,
  output logic                      cmd_valid_o,
  input  wire logic                 cmd_ready_i,
  output cmd_t                      cmd_o,
  output logic [TIME_BITS-1:0]      cmd_time_o
);

  cmd_t                 fifo_q [2];
  logic [TIME_BITS-1:0] time_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;
  logic                 push, pop, op_ok;
  logic [TIME_BITS-1:0] t_in;
  cmd_t                 cmd_in;

  if (TIME_BITS <= InTimeW) begin : g_trunc
    assign t_in = time_value_i[TIME_BITS-1:0];
  end else begin : g_ext
    assign t_in = {{(TIME_BITS-InTimeW){1'b0}}, time_value_i};
  end

  always_comb begin
    unique case (opcode_i)
      OP_SCHEDULE, OP_TICK, OP_CLEAR: op_ok = 1'b1;
      default:                        op_ok = 1'b0;
    endcase
    cmd_in.op     = opcode_e'(opcode_i);
    cmd_in.proc   = process_id_i;
    cmd_in.sleep  = sleep_request_i;
    cmd_in.msg    = has_message_i;
    cmd_in.queue  = queue_descriptor_i;
    cmd_in.handle = message_handle_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o && op_ok;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign cmd_time_o  = time_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
      time_q[wr_ptr_q] <= t_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[sv/atq_back.sv]
// Back end: sorted cell chain of alarms, tick sequencer and result register.
`default_nettype none
module atq_back
  import atq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  output logic                      cmd_ready_o,
  input  wire cmd_t                 cmd_i,
  input  wire logic [TIME_BITS-1:0] cmd_time_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                event_kind_o,
  output logic [31:0]               alarm_id_o,
  output logic [15:0]               owner_process_o,
  output logic [15:0]               target_queue_o,
  output logic [15:0]               payload_handle_o,
  output logic                      last_result_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [TIME_BITS-1:0] due_q [QUEUE_DEPTH];
  entry_t               ent_q [QUEUE_DEPTH];
  logic [CntW-1:0]      count_q, count_d;
  logic [31:0]          next_id_q, next_id_d;
  logic [TIME_BITS-1:0] tick_q;
  logic [PopCntW-1:0]   pop_cnt_q, pop_cnt_d;
  back_state_e          state_q, state_d;

  logic                 out_valid_q;
  event_kind_e          kind_d;
  logic [2:0]           kind_q;
  logic [31:0]          id_d, id_q;
  logic [15:0]          proc_d, proc_q, queue_d, queue_q, handle_d, handle_q;
  logic                 last_d, last_q;

  logic                 out_free, emit, do_insert, do_pop;
  logic [QUEUE_DEPTH-1:0] later;
  logic                 head_due, next_due, full;
  entry_t               new_ent;

  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (count_q >= CntW'(QUEUE_DEPTH));
  assign head_due = (count_q != '0) && (due_q[0] <= tick_q);
  assign next_due = (count_q > CntW'(1)) && (due_q[1] <= tick_q);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      later[i] = (CntW'(i) < count_q) &&
                 ((due_q[i] > cmd_time_i) ||
                  ((due_q[i] == cmd_time_i) && (ent_q[i].proc > cmd_i.proc)));
    end
    new_ent.proc   = cmd_i.proc;
    new_ent.id     = next_id_q;
    new_ent.sleep  = cmd_i.sleep;
    new_ent.msg    = cmd_i.msg;
    new_ent.queue  = cmd_i.queue;
    new_ent.handle = cmd_i.handle;
  end

  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_ready_o && cmd_i.op == OP_TICK) state_d = ST_TICK;
      end
      ST_TICK: begin
        if (out_free && (!head_due || pop_cnt_q == PopCntW'(MaxOut - 1) ||
                         !next_due)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    emit      = 1'b0;
    do_insert = 1'b0;
    do_pop    = 1'b0;
    kind_d    = EV_NONE;
    id_d      = '0;
    proc_d    = '0;
    queue_d   = '0;
    handle_d  = '0;
    last_d    = 1'b1;
    count_d   = count_q;
    next_id_d = next_id_q;
    pop_cnt_d = pop_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        pop_cnt_d = '0;
        if (cmd_valid_i && cmd_ready_o) begin
          unique case (cmd_i.op)
            OP_SCHEDULE: begin
              emit = 1'b1;
              if (full) begin
                kind_d = EV_FULL;
              end else begin
                do_insert = 1'b1;
                kind_d    = cmd_i.sleep ? EV_SCHED_SLP : EV_SCHEDULED;
                id_d      = next_id_q;
                proc_d    = cmd_i.proc;
                next_id_d = next_id_q + 32'd1;
                count_d   = count_q + CntW'(1);
              end
            end
            OP_CLEAR: begin
              emit    = 1'b1;
              kind_d  = EV_CLEARED;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (out_free) begin
          emit = 1'b1;
          if (head_due) begin
            do_pop    = 1'b1;
            count_d   = count_q - CntW'(1);
            pop_cnt_d = pop_cnt_q + PopCntW'(1);
            id_d      = ent_q[0].id;
            proc_d    = ent_q[0].proc;
            last_d    = (pop_cnt_q == PopCntW'(MaxOut - 1)) || !next_due;
            if (ent_q[0].sleep) begin
              kind_d = EV_WAKEUP;
            end else if (ent_q[0].msg) begin
              kind_d   = EV_MESSAGE;
              queue_d  = ent_q[0].queue;
              handle_d = ent_q[0].handle;
            end else begin
              kind_d = EV_SILENT;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) tick_q <= cmd_time_i;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_insert) begin
        if (i > 0 && later[(i > 0) ? i - 1 : 0]) begin
          due_q[i] <= due_q[(i > 0) ? i - 1 : 0];
          ent_q[i] <= ent_q[(i > 0) ? i - 1 : 0];
        end else if (later[i] || count_q == CntW'(i)) begin
          due_q[i] <= cmd_time_i;
          ent_q[i] <= new_ent;
        end
      end else if (do_pop && i < QUEUE_DEPTH - 1) begin
        due_q[i] <= due_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        ent_q[i] <= ent_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
    if (emit) begin
      kind_q   <= kind_d;
      id_q     <= id_d;
      proc_q   <= proc_d;
      queue_q  <= queue_d;
      handle_q <= handle_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      next_id_q   <= '0;
      pop_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      pop_cnt_q <= pop_cnt_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = kind_q;
  assign alarm_id_o       = id_q;
  assign owner_process_o  = proc_q;
  assign target_queue_o   = queue_q;
  assign payload_handle_o = handle_q;
  assign last_result_o    = last_q;

endmodule
`default_nettype wire

[sv/alarm_timer_queue.sv]
// Top level of the alarm timer queue: front end, command queue and back end.
// A schedule or clear request passes the command queue to the back end, which registers its single result.
// A tick holds the back end in its tick state, which shows one expired alarm
// per cycle while results are taken, at most 16, or an empty result if none is due.
// Schedules and clears pass one per cycle; a stalled result stalls the back end.
// Reset empties the alarm queue and sets the next alarm id to zero.
`default_nettype none
module alarm_timer_queue
  import atq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [InTimeW-1:0] time_value_i,
  input  wire logic [15:0]        process_id_i,
  input  wire logic               sleep_request_i,
  input  wire logic               has_message_i,
  input  wire logic [15:0]        queue_descriptor_i,
  input  wire logic [15:0]        message_handle_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              event_kind_o,
  output logic [31:0]             alarm_id_o,
  output logic [15:0]             owner_process_o,
  output logic [15:0]             target_queue_o,
  output logic [15:0]             payload_handle_o,
  output logic                    last_result_o
);

  logic                 cmd_valid, cmd_ready;
  cmd_t                 cmd;
  logic [TIME_BITS-1:0] cmd_time;

  atq_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .time_value_i,
    .process_id_i, .sleep_request_i, .has_message_i, .queue_descriptor_i,
    .message_handle_i,
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd),
    .cmd_time_o  (cmd_time)
  );

  atq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cmd_time_i  (cmd_time),
    .out_valid_o, .out_ready_i, .event_kind_o, .alarm_id_o, .owner_process_o,
    .target_queue_o, .payload_handle_o, .last_result_o
  );

endmodule
`default_nettype wire

[sv/atq_checker.sv]
// Port-level assertions for the alarm timer queue and their bind.
`default_nettype none
module atq_port_checks
  import atq_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  event_kind_o,
  input wire logic [31:0] alarm_id_o,
  input wire logic [15:0] owner_process_o,
  input wire logic [15:0] target_queue_o,
  input wire logic [15:0] payload_handle_o,
  input wire logic        last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o))
    else $error("result request dropped or changed while stalled");

  a_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_NONE || event_kind_o == EV_FULL ||
                    event_kind_o == EV_CLEARED) |-> alarm_id_o == '0 &&
                    owner_process_o == '0)
    else $error("id or process set on an event without an alarm");

  a_msg_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != EV_MESSAGE |->
      target_queue_o == '0 && payload_handle_o == '0)
    else $error("message fields set on a non-message event");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_NONE || event_kind_o == EV_SCHEDULED ||
                    event_kind_o == EV_SCHED_SLP || event_kind_o == EV_FULL ||
                    event_kind_o == EV_CLEARED) |-> last_result_o)
    else $error("single-result event not marked last");

endmodule

bind alarm_timer_queue atq_port_checks u_atq_port_checks (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .event_kind_o, .alarm_id_o,
  .owner_process_o, .target_queue_o, .payload_handle_o, .last_result_o
);
`default_nettype wire
